[sv/rebe_pkg.sv]
// Shared types and constants for the rotary encoder and push button event decoder.
`timescale 1ns / 1ps

package rebe_pkg;

   // Register map: index is csr_paddr[2] (word addresses 0x0 and 0x4)
   localparam logic CSR_HOLD_TICKS     = 1'b0;
   localparam logic CSR_EVENTS_ENABLED = 1'b1;

   localparam int unsigned HOLD_W  = 16;
   localparam int unsigned PRESS_W = 17;

   localparam logic [HOLD_W-1:0]  HOLD_TICKS_RESET = 16'd100;
   localparam logic [PRESS_W-1:0] PRESS_MAX        = 17'h1FFFF;

   // Channel pair codes, {chan_a, chan_b}
   localparam logic [1:0] PAIR_REST  = 2'b11;
   localparam logic [1:0] PAIR_RIGHT = 2'b01;
   localparam logic [1:0] PAIR_LEFT  = 2'b10;

   // Result flags, click in bit 0
   typedef struct packed {
      logic turn_left;
      logic turn_right;
      logic holding;
      logic long_hold;
      logic click;
   } event_type;

   // One poll tick, button_level in bit 0
   typedef struct packed {
      logic chan_b;
      logic chan_a;
      logic button_level;
   } tick_type;

endpackage

[sv/rotary_encoder_button_events.sv]
// Rotary encoder with push button: turns poll ticks into click, hold and turn events.
`timescale 1ns / 1ps

//  channel  | direction | handshake             | payload
//  req_     | in        | req_tvalid/req_tready | tdata[2:0] = button_level, chan_a, chan_b
//  rsp_     | out       | rsp_tvalid/rsp_tready | tdata[4:0] = click, long_hold, holding,
//           |           |                       |              turn_right, turn_left
//  csr_     | in        | APB write/read        | 0x0 hold_ticks[15:0], 0x4 events_enabled[0]
//
//  One item per cycle sustained while rsp_tready is high: an item waits in the input register,
//  then the decode and all state updates happen together on the way into the result register.
//  rsp_tvalid rises when the decoded item reaches the result register; ticks with no event produce no item.
//  A stalled rsp_ side holds the result register and the input register backs up behind it;
//  req_tready drops only when both are full and rsp_tready is low.
//  Synchronous active-high reset clears all control and decoder state; hold_ticks resets
//  to 100 and events_enabled to 0.

module rotary_encoder_button_events (
   input  logic        clock,
   input  logic        reset,
   // input items
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [0] button_level, [1] chan_a, [2] chan_b, rest zero
   // result items
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [0] click, [1] long_hold, [2] holding,
                                    // [3] turn_right, [4] turn_left, rest zero
   // configuration
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   // configuration registers
   logic [rebe_pkg::HOLD_W-1:0] hold_ticks_ff, hold_ticks_in;
   logic                        events_enabled_ff, events_enabled_in;

   // input register
   logic                 s1_valid_ff, s1_valid_in;
   rebe_pkg::tick_type   s1_tick_ff, s1_tick_in;

   // decoder state
   logic                         button_last_ff, button_last_in;
   logic [rebe_pkg::PRESS_W-1:0] press_length_ff, press_length_in;
   logic [rebe_pkg::HOLD_W-1:0]  hold_phase_ff, hold_phase_in;
   logic [1:0]                   chan_cand_ff, chan_cand_in;
   logic [1:0]                   chan_acc_ff, chan_acc_in;

   // result register
   logic                 rsp_valid_ff, rsp_valid_in;
   rebe_pkg::event_type  rsp_event_ff, rsp_event_in;

   logic csr_write;
   logic advance;     // result register can take a new value this cycle
   logic process;     // the tick in the input register is decoded this cycle

   // decode terms
   rebe_pkg::event_type           ev;
   logic [1:0]                    pair;
   logic                          prev;
   logic [rebe_pkg::PRESS_W-1:0]  press_base;
   logic [rebe_pkg::HOLD_W-1:0]   phase_base;
   logic [rebe_pkg::HOLD_W:0]     phase_inc;
   logic                          phase_hit;

   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   always_comb begin
      case (csr_paddr[2])
         rebe_pkg::CSR_HOLD_TICKS:     csr_prdata = {16'd0, hold_ticks_ff};
         rebe_pkg::CSR_EVENTS_ENABLED: csr_prdata = {31'd0, events_enabled_ff};
         default:                      csr_prdata = 32'd0;
      endcase
   end

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || advance;
   assign process    = s1_valid_ff && advance && events_enabled_ff;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'd0, rsp_event_ff};

   always_comb begin
      hold_ticks_in     = hold_ticks_ff;
      events_enabled_in = events_enabled_ff;
      if (csr_write) begin
         case (csr_paddr[2])
            rebe_pkg::CSR_HOLD_TICKS:     hold_ticks_in     = csr_pwdata[15:0];
            rebe_pkg::CSR_EVENTS_ENABLED: events_enabled_in = csr_pwdata[0];
            default: ;
         endcase
      end
   end

   // input register
   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_tick_in  = s1_tick_ff;
      if (req_tvalid && req_tready) begin
         s1_valid_in = 1'b1;
         s1_tick_in  = req_tdata[2:0];
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
   end

   // decode of the tick held in the input register
   always_comb begin
      pair = {s1_tick_ff.chan_a, s1_tick_ff.chan_b};
      prev = button_last_ff;
      ev   = '0;

      button_last_in  = button_last_ff;
      press_length_in = press_length_ff;
      hold_phase_in   = hold_phase_ff;
      chan_cand_in    = chan_cand_ff;
      chan_acc_in     = chan_acc_ff;

      // a new press restarts both counters
      press_base = prev ? '0 : press_length_ff;
      phase_base = prev ? '0 : hold_phase_ff;
      phase_inc  = {1'b0, phase_base} + 17'd1;
      phase_hit  = phase_inc >= {1'b0, hold_ticks_ff};

      if (s1_tick_ff.button_level && !prev) begin
         // release after a press
         ev.click     = 1'b1;
         ev.long_hold = press_length_ff > {1'b0, hold_ticks_ff};
      end else if (!s1_tick_ff.button_level) begin
         ev.holding      = 1'b1;
         press_length_in = (press_base == rebe_pkg::PRESS_MAX) ? press_base
                                                               : press_base + 17'd1;
         ev.long_hold    = phase_hit;
         hold_phase_in   = phase_hit ? '0 : phase_inc[rebe_pkg::HOLD_W-1:0];
      end
      button_last_in = s1_tick_ff.button_level;

      // a pair counts only after it shows up on two ticks in a row
      if (pair != chan_cand_ff) begin
         chan_cand_in = pair;
      end else begin
         ev.turn_right = (chan_acc_ff == rebe_pkg::PAIR_REST) && (pair == rebe_pkg::PAIR_RIGHT);
         ev.turn_left  = (chan_acc_ff == rebe_pkg::PAIR_REST) && (pair == rebe_pkg::PAIR_LEFT);
         chan_acc_in   = pair;
      end

      if (!process) begin
         button_last_in  = button_last_ff;
         press_length_in = press_length_ff;
         hold_phase_in   = hold_phase_ff;
         chan_cand_in    = chan_cand_ff;
         chan_acc_in     = chan_acc_ff;
      end
   end

   // result register; holding alone is not reported
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_event_in = rsp_event_ff;
      if (advance) begin
         rsp_valid_in = process &&
                        (ev.click || ev.long_hold || ev.turn_right || ev.turn_left);
         rsp_event_in = ev;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ticks_ff     <= rebe_pkg::HOLD_TICKS_RESET;
         events_enabled_ff <= 1'b0;
         s1_valid_ff       <= 1'b0;
         button_last_ff    <= 1'b1;
         press_length_ff   <= '0;
         hold_phase_ff     <= '0;
         chan_cand_ff      <= 2'd0;
         chan_acc_ff       <= 2'd0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         hold_ticks_ff     <= hold_ticks_in;
         events_enabled_ff <= events_enabled_in;
         s1_valid_ff       <= s1_valid_in;
         button_last_ff    <= button_last_in;
         press_length_ff   <= press_length_in;
         hold_phase_ff     <= hold_phase_in;
         chan_cand_ff      <= chan_cand_in;
         chan_acc_ff       <= chan_acc_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_tick_ff   <= s1_tick_in;
      rsp_event_ff <= rsp_event_in;
   end

   // a reported item always carries an event other than holding
   a_rsp_has_event: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_event_ff.click || rsp_event_ff.long_hold ||
                        rsp_event_ff.turn_right || rsp_event_ff.turn_left))
      else $error("result item without an event");

   a_turn_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_event_ff.turn_right && rsp_event_ff.turn_left))
      else $error("left and right turn in one item");

   a_click_not_holding: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_event_ff.click && rsp_event_ff.holding))
      else $error("click reported while button held");

   // disabled decoder leaves its state alone
   a_disabled_frozen: assert property (@(posedge clock) disable iff (reset)
      !events_enabled_ff |=> ($stable(press_length_ff) && $stable(hold_phase_ff) &&
                              $stable(chan_acc_ff) && $stable(button_last_ff)))
      else $error("decoder state changed while disabled");

endmodule

[verif/tb_rotary_encoder_button_events.sv]
// Testbench for the rotary encoder and push button event decoder: predicted vs. actual events.
`timescale 1ns / 1ps

module tb_rotary_encoder_button_events;

   // Half period of a 4 ns clock
   localparam int unsigned HALF_PERIOD    = 2;
   localparam int unsigned RESET_CYCLES   = 6;
   // Extra wait after the expected-event queue drains, for ticks that give no event
   localparam int unsigned DRAIN_CYCLES   = 8;
   // Above the slowest legal gap: a sender gap, the pipeline, a receiver stall and a CSR access
   localparam int unsigned WATCHDOG_LIMIT = 600;
   localparam int unsigned MAX_REPORTS    = 10;
   localparam int unsigned MAX_IDLE       = 14;

   // Both channels low, the midpoint of a detent step
   localparam logic [1:0] PAIR_BOTH_LOW = 2'b00;

   // ------------------------------------------------------------------------
   // Event predictor and checker
   // ------------------------------------------------------------------------
   class encoder_event_checker;
      // register copies
      logic [rebe_pkg::HOLD_W-1:0]  period_ticks = rebe_pkg::HOLD_TICKS_RESET;
      logic                         active       = 1'b0;
      // decoder state copies
      logic                         btn_prev     = 1'b1;
      logic [rebe_pkg::PRESS_W-1:0] press_count  = '0;
      logic [rebe_pkg::HOLD_W-1:0]  period_count = '0;
      logic [1:0]                   pair_seen    = '0;
      logic [1:0]                   pair_stable  = '0;

      rebe_pkg::event_type          expected_events[$];
      int unsigned                  errors       = 0;

      function void report(string msg);
         errors++;
         if (errors <= MAX_REPORTS)
            $display("%s", msg);
      endfunction

      function void set_reg(logic idx, logic [31:0] value);
         case (idx)
            rebe_pkg::CSR_HOLD_TICKS:     period_ticks = value[rebe_pkg::HOLD_W-1:0];
            rebe_pkg::CSR_EVENTS_ENABLED: active       = value[0];
            default: ;
         endcase
      endfunction

      function logic [31:0] reg_value(logic idx);
         return (idx == rebe_pkg::CSR_HOLD_TICKS) ? 32'(period_ticks) : 32'(active);
      endfunction

      // One poll tick through the decoder; returns 1 when it yields an event item
      function bit predict(rebe_pkg::tick_type t, output rebe_pkg::event_type ev);
         logic                        was_high;
         logic [1:0]                  pair;
         logic [rebe_pkg::HOLD_W:0]   next_count;
         ev = '0;
         if (!active)
            return 1'b0;
         pair     = {t.chan_a, t.chan_b};
         was_high = btn_prev;
         btn_prev = t.button_level;

         if (t.button_level && !was_high) begin
            // release: a click, long if the press outlasted the period
            ev.click = 1'b1;
            if (press_count > {1'b0, period_ticks})
               ev.long_hold = 1'b1;
         end else if (!t.button_level) begin
            ev.holding = 1'b1;
            if (was_high) begin
               press_count  = '0;
               period_count = '0;
            end
            if (press_count != rebe_pkg::PRESS_MAX)
               press_count++;
            next_count = {1'b0, period_count} + 1'b1;
            if (next_count >= {1'b0, period_ticks}) begin
               ev.long_hold = 1'b1;
               period_count = '0;
            end else begin
               period_count = next_count[rebe_pkg::HOLD_W-1:0];
            end
         end

         // a pair must be seen twice in a row before it counts
         if (pair != pair_seen) begin
            pair_seen = pair;
         end else begin
            if (pair_stable == rebe_pkg::PAIR_REST && pair == rebe_pkg::PAIR_RIGHT)
               ev.turn_right = 1'b1;
            else if (pair_stable == rebe_pkg::PAIR_REST && pair == rebe_pkg::PAIR_LEFT)
               ev.turn_left = 1'b1;
            pair_stable = pair;
         end

         return ev.click | ev.long_hold | ev.turn_right | ev.turn_left;
      endfunction

      function void note_tick(rebe_pkg::tick_type t);
         rebe_pkg::event_type ev;
         if (predict(t, ev))
            expected_events.push_back(ev);
      endfunction

      function void check_event(logic [7:0] got);
         rebe_pkg::event_type want;
         if (expected_events.size() == 0) begin
            report($sformatf("unexpected event item %b", got));
            return;
         end
         want = expected_events.pop_front();
         if (got !== {3'b000, want})
            report($sformatf({"event mismatch: expected click=%0b long_hold=%0b holding=%0b ",
                              "right=%0b left=%0b, got tdata=%b"},
                             want.click, want.long_hold, want.holding,
                             want.turn_right, want.turn_left, got));
      endfunction

      function int unsigned pending();
         return expected_events.size();
      endfunction
   endclass

   // ------------------------------------------------------------------------
   // DUT signals, all inputs known from time zero
   // ------------------------------------------------------------------------
   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata   = '0;   // [0] button_level, [1] chan_a, [2] chan_b
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [7:0]  rsp_tdata;          // [0] click, [1] long_hold, [2] holding,
                                    // [3] turn_right, [4] turn_left
   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [2:0]  csr_paddr   = '0;
   logic [31:0] csr_pwdata  = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   encoder_event_checker board = new;

   // idle controls, changed per phase
   bit          src_gaps    = 1'b0;
   bit          sink_stalls = 1'b0;
   int unsigned idle_cycles = 0;

   // random tick generator state; persists across phases so a press can span a reg write
   logic        gen_btn     = 1'b1;
   logic [1:0]  gen_pair    = rebe_pkg::PAIR_REST;
   bit          turn_cw     = 1'b1;
   int unsigned btn_run     = 0;
   int unsigned pair_run    = 0;
   int unsigned press_span  = 4;

   rotary_encoder_button_events u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // ------------------------------------------------------------------------
   // Monitors: sample at the edge, before the DUT's own updates land
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready)
         board.note_tick(rebe_pkg::tick_type'(req_tdata[2:0]));
      if (!reset && rsp_tvalid && rsp_tready)
         board.check_event(rsp_tdata);
   end

   // Watchdog: any accepted item or CSR access counts as progress
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_psel) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   // Result receiver: after each accepted item draw a stall, keep tready high when zero
   initial begin
      int unsigned stall;
      @(negedge reset);
      @(posedge clock);
      rsp_tready <= 1'b1;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) begin
            stall = sink_stalls ? $urandom_range(0, MAX_IDLE) : 0;
            if (stall > 0) begin
               rsp_tready <= 1'b0;
               repeat (stall) @(posedge clock);
               rsp_tready <= 1'b1;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Drivers
   // ------------------------------------------------------------------------

   // One poll tick; returns at the edge where it was accepted, tvalid still high
   task automatic send_tick(logic btn, logic chan_a, logic chan_b);
      rebe_pkg::tick_type t;
      int unsigned        gap;
      gap = src_gaps ? $urandom_range(0, MAX_IDLE) : 0;
      t.button_level = btn;
      t.chan_a       = chan_a;
      t.chan_b       = chan_b;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {5'b00000, t};
      do @(posedge clock); while (!req_tready);
   endtask

   // Write a register, then read it back
   task automatic csr_write(logic idx, logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      board.set_reg(idx, value);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata !== board.reg_value(idx))
         board.report($sformatf("register %0d readback: expected %h, got %h",
                                idx, board.reg_value(idx), csr_prdata));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Let every expected event out, plus a margin for ticks that give none
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (board.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Next pair along the quadrature cycle: cw 11-01-00-10, ccw 11-10-00-01
   function automatic logic [1:0] next_pair(logic [1:0] pair, bit cw);
      case (pair)
         rebe_pkg::PAIR_REST:  return cw ? rebe_pkg::PAIR_RIGHT : rebe_pkg::PAIR_LEFT;
         rebe_pkg::PAIR_RIGHT: return cw ? PAIR_BOTH_LOW        : rebe_pkg::PAIR_REST;
         PAIR_BOTH_LOW:        return cw ? rebe_pkg::PAIR_LEFT  : rebe_pkg::PAIR_RIGHT;
         default:              return cw ? rebe_pkg::PAIR_REST  : PAIR_BOTH_LOW;
      endcase
   endfunction

   // Mostly proper detent steps and presses, with bounces and random jumps mixed in
   task automatic random_phase(int unsigned n_ticks);
      int unsigned k;
      for (k = 0; k < n_ticks; k++) begin
         if (btn_run == 0) begin
            gen_btn = ~gen_btn;
            btn_run = gen_btn ? $urandom_range(1, 20) : $urandom_range(1, 3 * press_span + 2);
         end
         if (pair_run == 0) begin
            if ($urandom_range(0, 9) == 0)
               turn_cw = ~turn_cw;
            if ($urandom_range(0, 4) == 0)
               gen_pair = 2'($urandom);
            else
               gen_pair = next_pair(gen_pair, turn_cw);
            // a single tick is a bounce that the filter must drop
            pair_run = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(2, 4);
         end
         btn_run--;
         pair_run--;
         send_tick(gen_btn, gen_pair[1], gen_pair[0]);
      end
   endtask

   task automatic random_setting(logic [rebe_pkg::HOLD_W-1:0] hold, int unsigned span,
                                 bit gaps, bit stalls, int unsigned n_ticks);
      drain();
      csr_write(rebe_pkg::CSR_HOLD_TICKS, 32'(hold));
      press_span  = span;
      src_gaps    = gaps;
      sink_stalls = stalls;
      random_phase(n_ticks);
   endtask

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------
   initial begin
      int unsigned k;
      logic [rebe_pkg::HOLD_W-1:0] hold;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Disabled after reset: presses and turns are dropped, state untouched
      send_tick(1'b0, 1'b1, 1'b1);
      send_tick(1'b0, 1'b1, 1'b1);
      send_tick(1'b1, 1'b0, 1'b1);
      send_tick(1'b1, 1'b0, 1'b1);
      drain();
      csr_write(rebe_pkg::CSR_HOLD_TICKS, 32'd2);
      csr_write(rebe_pkg::CSR_EVENTS_ENABLED, 32'd1);

      // Detent right: settle on 11, then 01 seen twice
      send_tick(1'b1, 1'b1, 1'b1);
      send_tick(1'b1, 1'b1, 1'b1);
      send_tick(1'b1, 1'b0, 1'b1);
      send_tick(1'b1, 1'b0, 1'b1);
      // back round to 11, then detent left with 10
      send_tick(1'b1, 1'b0, 1'b0);
      send_tick(1'b1, 1'b0, 1'b0);
      send_tick(1'b1, 1'b1, 1'b1);
      send_tick(1'b1, 1'b1, 1'b1);
      send_tick(1'b1, 1'b1, 1'b0);
      send_tick(1'b1, 1'b1, 1'b0);

      // Press of three ticks at a period of two: long hold mid-press, long click on release
      send_tick(1'b0, 1'b1, 1'b0);
      send_tick(1'b0, 1'b1, 1'b0);
      send_tick(1'b0, 1'b1, 1'b0);
      send_tick(1'b1, 1'b1, 1'b0);
      // short press: plain click
      send_tick(1'b0, 1'b1, 1'b0);
      send_tick(1'b1, 1'b1, 1'b0);

      // Lower the period mid-press: fires on the next pressed tick
      drain();
      csr_write(rebe_pkg::CSR_HOLD_TICKS, 32'(rebe_pkg::HOLD_TICKS_RESET));
      for (k = 0; k < 6; k++)
         send_tick(1'b0, 1'b1, 1'b1);
      drain();
      csr_write(rebe_pkg::CSR_HOLD_TICKS, 32'd3);
      send_tick(1'b0, 1'b1, 1'b1);
      send_tick(1'b1, 1'b1, 1'b1);

      // Zero period: long hold on every pressed tick, any press is long on release
      drain();
      csr_write(rebe_pkg::CSR_HOLD_TICKS, 32'd0);
      send_tick(1'b0, 1'b1, 1'b1);
      send_tick(1'b0, 1'b1, 1'b1);
      send_tick(1'b1, 1'b1, 1'b1);

      // Random phases over several periods and idle mixes
      random_setting(16'd3, 3, 1'b1, 1'b1, 300);
      random_setting(16'd1, 2, 1'b1, 1'b0, 250);
      random_setting(16'd0, 1, 1'b0, 1'b0, 200);
      hold = 16'($urandom_range(2, 12));
      random_setting(hold, int'(hold), 1'b0, 1'b1, 300);

      // Disable for a stretch: ticks dropped, then pick up where state was left
      drain();
      csr_write(rebe_pkg::CSR_EVENTS_ENABLED, 32'd0);
      src_gaps = 1'b1;
      random_phase(60);
      drain();
      csr_write(rebe_pkg::CSR_EVENTS_ENABLED, 32'd1);

      random_setting(16'hFFFF, 40, 1'b1, 1'b1, 250);
      random_setting(16'd5, 5, 1'b0, 1'b0, 220);
      hold = 16'($urandom_range(1, 10));
      random_setting(hold, int'(hold), 1'b1, 1'b1, 250);

      drain();
      if (board.errors == 0 && board.pending() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
